// File: design/u2u8_pkg.sv
// Shared types, constants and UTF-8 encoding helpers for the UTF-16/UTF-32 to UTF-8 transcoder.
// No dependencies; used by every module of the block.
package u2u8_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       char_end;
    logic       stream_end;
  } out_item_t;

  // One decoded request: one or two code points, plus end-of-stream marker.
  typedef struct packed {
    logic [20:0] cp0;
    logic [20:0] cp1;
    logic        two;
    logic        last;
  } job_t;

  typedef enum logic [1:0] {
    MODE_U16LE = 2'd0,
    MODE_U16BE = 2'd1,
    MODE_U32LE = 2'd2,
    MODE_U32BE = 2'd3
  } mode_t;

  localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;
  localparam logic [31:0] CP_MAX      = 32'h0010FFFF;
  localparam logic [15:0] BOM         = 16'hFEFF;
  localparam logic [15:0] SUR_FIRST   = 16'hD800;
  localparam logic [15:0] HIGH_LAST   = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST   = 16'hDC00;
  localparam logic [15:0] SUR_LAST    = 16'hDFFF;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp < 21'h000080) begin
      len = 3'd1;
    end else if (cp < 21'h000800) begin
      len = 3'd2;
    end else if (cp < 21'h010000) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [1:0] idx);
    logic [7:0] b;
    unique case (len)
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        unique case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0: b = {5'b11110, cp[20:18]};
          2'd1: b = {2'b10, cp[17:12]};
          2'd2: b = {2'b10, cp[11:6]};
          2'd3: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// File: design/u2u8_front.sv
// Front end: mode register, unit assembly, mark/surrogate handling; emits decode requests.
// Depends on u2u8_pkg.
module u2u8_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_data,
  input  logic               accept,
  input  u2u8_pkg::in_item_t item,
  output u2u8_pkg::job_t     job,
  output logic               job_valid
);

  u2u8_pkg::mode_t mode;
  logic [1:0]  cnt, cnt_next;
  logic [23:0] bytes, bytes_next;
  logic        hp, hp_next;
  logic [9:0]  hb, hb_next;
  logic        start, start_next;

  logic        wide, little, mark;
  logic [7:0]  b;
  logic [15:0] u16;
  logic [31:0] u32;
  logic [20:0] cp0, cp1;
  logic [1:0]  nc;

  assign b      = item.in_byte;
  assign wide   = (mode == u2u8_pkg::MODE_U32LE) || (mode == u2u8_pkg::MODE_U32BE);
  assign little = (mode == u2u8_pkg::MODE_U16LE) || (mode == u2u8_pkg::MODE_U32LE);
  assign u16    = little ? {b, bytes[7:0]} : {bytes[7:0], b};
  assign u32    = little ? {b, bytes[7:0], bytes[15:8], bytes[23:16]} : {bytes, b};

  always_comb begin
    cnt_next   = cnt;
    bytes_next = bytes;
    hp_next    = hp;
    hb_next    = hb;
    start_next = start;
    cp0        = u2u8_pkg::REPLACEMENT;
    cp1        = u2u8_pkg::REPLACEMENT;
    nc         = 2'd0;
    mark       = 1'b0;
    if (!wide) begin
      if (cnt == 2'd0) begin
        bytes_next = {16'd0, b};
        cnt_next   = 2'd1;
      end else begin
        cnt_next   = 2'd0;
        bytes_next = 24'd0;
        if (start) begin
          start_next = 1'b0;
          mark       = (u16 == u2u8_pkg::BOM);
        end
        if (!mark) begin
          if (hp && u16 >= u2u8_pkg::LOW_FIRST && u16 <= u2u8_pkg::SUR_LAST) begin
            hp_next = 1'b0;
            hb_next = 10'd0;
            cp0     = u2u8_pkg::SUPP_BASE + {1'b0, hb, u16[9:0]};
            nc      = 2'd1;
          end else begin
            if (hp) begin
              // broken pair: replacement, then decode this unit on its own
              hp_next = 1'b0;
              hb_next = 10'd0;
              cp0     = u2u8_pkg::REPLACEMENT;
              nc      = 2'd1;
            end
            if (u16 < u2u8_pkg::SUR_FIRST || u16 > u2u8_pkg::SUR_LAST) begin
              if (nc == 2'd0) cp0 = {5'd0, u16};
              else            cp1 = {5'd0, u16};
              nc = nc + 2'd1;
            end else if (u16 > u2u8_pkg::HIGH_LAST) begin
              if (nc == 2'd0) cp0 = u2u8_pkg::REPLACEMENT;
              else            cp1 = u2u8_pkg::REPLACEMENT;
              nc = nc + 2'd1;
            end else begin
              hp_next = 1'b1;
              hb_next = u16[9:0];
            end
          end
        end
      end
    end else begin
      if (cnt != 2'd3) begin
        bytes_next = {bytes[15:0], b};
        cnt_next   = cnt + 2'd1;
      end else begin
        cnt_next   = 2'd0;
        bytes_next = 24'd0;
        hp_next    = 1'b0;
        hb_next    = 10'd0;
        if (start) begin
          start_next = 1'b0;
          mark       = (u32 == {16'd0, u2u8_pkg::BOM});
        end
        if (!mark) begin
          if (u32 <= u2u8_pkg::CP_MAX &&
              (u32 < {16'd0, u2u8_pkg::SUR_FIRST} || u32 > {16'd0, u2u8_pkg::SUR_LAST})) begin
            cp0 = u32[20:0];
          end else begin
            cp0 = u2u8_pkg::REPLACEMENT;
          end
          nc = 2'd1;
        end
      end
    end
    if (item.in_last) begin
      if (!wide && hp_next) begin
        if (nc == 2'd0) cp0 = u2u8_pkg::REPLACEMENT;
        else            cp1 = u2u8_pkg::REPLACEMENT;
        nc = nc + 2'd1;
      end
      if (cnt_next != 2'd0) begin
        if (nc == 2'd0) cp0 = u2u8_pkg::REPLACEMENT;
        else            cp1 = u2u8_pkg::REPLACEMENT;
        nc = nc + 2'd1;
      end
      cnt_next   = 2'd0;
      bytes_next = 24'd0;
      hp_next    = 1'b0;
      hb_next    = 10'd0;
      start_next = 1'b1;
    end
  end

  always_comb begin
    job.cp0   = cp0;
    job.cp1   = cp1;
    job.two   = (nc == 2'd2);
    job.last  = item.in_last;
    job_valid = (nc != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= u2u8_pkg::MODE_U16LE;
      cnt   <= 2'd0;
      bytes <= 24'd0;
      hp    <= 1'b0;
      hb    <= 10'd0;
      start <= 1'b1;
    end else begin
      if (cfg_write) begin
        mode <= u2u8_pkg::mode_t'(cfg_data);
      end
      if (accept) begin
        cnt   <= cnt_next;
        bytes <= bytes_next;
        hp    <= hp_next;
        hb    <= hb_next;
        start <= start_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a pending high surrogate only lives in a UTF-16 stream that has started
  a_hp_not_at_start: assert property (@(posedge clk) disable iff (rst)
    hp |-> !start) else $error("high surrogate pending at stream start");
  // a last byte always leaves the stream state clean
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && item.in_last |=> start && !hp && cnt == 2'd0)
    else $error("stream state not cleared after last byte");
`endif

endmodule

// File: design/u2u8_queue.sv
// Short request queue between front end and encoder.
// Depends on u2u8_pkg for the request type.
module u2u8_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  u2u8_pkg::job_t wr_data,
  output logic           full,
  input  logic           rd,
  output u2u8_pkg::job_t rd_data,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u2u8_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> !full || rd) else $error("request queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> !empty) else $error("request queue underflow");
`endif

endmodule

// File: design/u2u8_back.sv
// Encoder: queued code points to UTF-8, one byte per cycle while its output register is free.
// Depends on u2u8_pkg for types and the encoding helpers.
module u2u8_back (
  input  logic                clk,
  input  logic                rst,
  input  u2u8_pkg::job_t      job_in,
  input  logic                job_avail,
  output logic                job_take,
  output u2u8_pkg::out_item_t result,
  output logic                empty,
  input  logic                pop
);

  u2u8_pkg::job_t      cur;
  logic                cur_valid;
  logic                sel;
  logic [1:0]          idx;
  u2u8_pkg::out_item_t out_reg;
  logic                out_valid;

  logic [20:0] cp;
  logic [2:0]  len;
  logic [7:0]  ubyte;
  logic        char_end, last_cp, job_done, advance;

  always_comb begin
    cp       = sel ? cur.cp1 : cur.cp0;
    len      = u2u8_pkg::utf8_len(cp);
    ubyte    = u2u8_pkg::utf8_byte(cp, len, idx);
    char_end = ({1'b0, idx} == len - 3'd1);
    last_cp  = !cur.two || sel;
    job_done = char_end && last_cp;
    advance  = cur_valid && (!out_valid || pop);
    job_take = job_avail && (!cur_valid || (advance && job_done));
  end

  assign result = out_reg;
  assign empty  = !out_valid;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg.out_byte   <= ubyte;
      out_reg.char_end   <= char_end;
      out_reg.stream_end <= job_done && cur.last;
    end
    if (job_take) begin
      cur <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      sel       <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (job_take) begin
        cur_valid <= 1'b1;
        sel       <= 1'b0;
        idx       <= 2'd0;
      end else if (advance) begin
        if (char_end) begin
          idx <= 2'd0;
          sel <= !job_done;
          if (job_done) begin
            cur_valid <= 1'b0;
          end
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_end_on_char: assert property (@(posedge clk) disable iff (rst)
    !empty && result.stream_end |-> result.char_end)
    else $error("stream end flag off a character boundary");
  a_second_cp: assert property (@(posedge clk) disable iff (rst)
    cur_valid && sel |-> cur.two) else $error("second code point selected on single request");
`endif

endmodule

// File: design/utf16_utf32_to_utf8_transcoder_core.sv
// UTF-16/UTF-32 to UTF-8 transcoder, top level. Raw bytes are pushed one per cycle whenever
// full is low; the front end assembles units, drops a leading byte order mark, pairs
// surrogates and queues one request, with up to two code points (replacement characters
// included), for each byte that yields output. The encoder drains that queue and delivers at
// most one UTF-8 byte per cycle while pop keeps its output register free; a byte of input
// can cause up to 6 output bytes, so the encoder can fall behind and full then holds the input
// back; the encoder's one-byte-per-cycle output register sets the rate.
// Depends on u2u8_pkg, u2u8_front, u2u8_queue, u2u8_back.
module utf16_utf32_to_utf8_transcoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_data,
  input  logic                push,
  output logic                full,
  input  u2u8_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output u2u8_pkg::out_item_t result
);

  u2u8_pkg::job_t fr_job, q_job;
  logic           fr_valid, accept, q_empty, take;

  assign accept = push && !full;

  u2u8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .job       (fr_job),
    .job_valid (fr_valid)
  );

  u2u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept && fr_valid),
    .wr_data (fr_job),
    .full    (full),
    .rd      (take),
    .rd_data (q_job),
    .empty   (q_empty)
  );

  u2u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_in    (q_job),
    .job_avail (!q_empty),
    .job_take  (take),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
